>>> sv/csd_pkg.sv
// Shared constants, types and helpers for the card shoe dealer.
package csd_pkg;

	localparam int MAX_CARDS = 512;
	localparam int IDX_W = $clog2(MAX_CARDS);
	localparam int CNT_W = $clog2(MAX_CARDS + 1);
	localparam int DECK_W = 10;
	localparam int RND_W = 31;
	localparam int CARD_W = 9;
	localparam int LEFT_W = 9;
	localparam int STEP_W = $clog2(RND_W);
	localparam logic [DECK_W-1:0] DECK_RESET = DECK_W'(52);

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		logic [IDX_W-1:0] data;
	} store_wr_t;

	function automatic logic [CNT_W-1:0] eff_size(input logic [DECK_W-1:0] n);
		logic [CNT_W-1:0] r;
		if (n < DECK_W'(2)) begin
			r = CNT_W'(2);
		end else if (32'(n) > 32'(MAX_CARDS)) begin
			r = CNT_W'(MAX_CARDS);
		end else begin
			r = CNT_W'(n);
		end
		return r;
	endfunction

endpackage

>>> sv/csd_mod.sv
// Bit-serial remainder unit: reduces the random word modulo the cards left.
module csd_mod (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [csd_pkg::RND_W-1:0] dividend,
	input  logic [csd_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [csd_pkg::IDX_W-1:0] rem
);
	import csd_pkg::*;

	logic              run_q;
	logic [STEP_W-1:0] step_q;
	logic [RND_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W-1:0]  rem_next;

	assign trial = {rem_q, dvd_q[RND_W-1]};

	always_comb begin
		if (trial >= {1'b0, dvs_q}) begin
			rem_next = CNT_W'(trial - {1'b0, dvs_q});
		end else begin
			rem_next = trial[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				step_q <= STEP_W'(RND_W - 1);
			end else if (run_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == '0) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign rem = rem_q[IDX_W-1:0];

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !run_q)
		else $error("remainder unit still running when done");
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> run_q)
		else $error("remainder unit did not start");
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> rem_q < dvs_q)
		else $error("remainder not below the divisor");
endmodule

>>> sv/csd_store.sv
// Card store: one write port and one registered read port.
module csd_store (
	input  logic                      clk,
	input  csd_pkg::store_wr_t        wr,
	input  logic [csd_pkg::IDX_W-1:0] rd_addr,
	output logic [csd_pkg::IDX_W-1:0] rd_data
);
	import csd_pkg::*;

	logic [IDX_W-1:0] mem [MAX_CARDS];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

>>> sv/card_shoe_shuffle_dealer.sv
// Card shoe dealer top level: draw sequencer, store refill and deck size register.
//
// Channel  Signals                          Handshake
// config   deck_size_we, deck_size          written when deck_size_we is high
// input    start, random_value, busy        word taken when start and not busy
// result   done, card, cards_left, refilled one cycle, marked by done
//
// A draw runs from acceptance to done through 31 steps of the remainder
// unit, then a read of the top and the chosen entry and two writes back.
// A draw that empties the shoe is followed by a refill of all 512 store entries.
// After reset the same pass writes the identity; busy stays high.
// The receiver cannot stall; done lasts one cycle.
module card_shoe_shuffle_dealer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       deck_size_we,
	input  logic [csd_pkg::DECK_W-1:0] deck_size,
	input  logic                       start,
	input  logic [csd_pkg::RND_W-1:0]  random_value,
	output logic                       busy,
	output logic                       done,
	output logic [csd_pkg::CARD_W-1:0] card,
	output logic [csd_pkg::LEFT_W-1:0] cards_left,
	output logic                       refilled
);
	import csd_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_RDC,
		S_RDP,
		S_RDV,
		S_WRC,
		S_WRP,
		S_FILL
	} state_t;

	state_t            state_q;
	logic [DECK_W-1:0] deck_size_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  c_w;
	logic [IDX_W-1:0]  idx_c;
	logic [IDX_W-1:0]  p_q;
	logic [IDX_W-1:0]  val_c_q;
	logic [IDX_W-1:0]  val_p_q;
	logic [IDX_W-1:0]  fill_q;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  rd_data;
	logic [IDX_W-1:0]  div_rem;
	logic              div_start;
	logic              div_done;
	store_wr_t         wr;

	assign busy = (state_q != S_IDLE);
	assign c_w = count_q - CNT_W'(1);
	assign idx_c = c_w[IDX_W-1:0];
	assign div_start = start && !busy;
	assign rd_addr = (state_q == S_RDP) ? p_q : idx_c;

	always_comb begin
		case (state_q)
			S_FILL: wr = '{we: 1'b1, addr: fill_q, data: fill_q};
			S_WRC: wr = '{we: 1'b1, addr: idx_c, data: val_p_q};
			S_WRP: wr = '{we: 1'b1, addr: p_q, data: val_c_q};
			default: wr = '{we: 1'b0, addr: '0, data: '0};
		endcase
	end

	csd_mod u_mod (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(random_value),
		.divisor(count_q),
		.done(div_done),
		.rem(div_rem)
	);

	csd_store u_store (
		.clk(clk),
		.wr(wr),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deck_size_q <= DECK_RESET;
		end else if (deck_size_we) begin
			deck_size_q <= deck_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			fill_q <= '0;
			count_q <= eff_size(DECK_RESET);
			p_q <= '0;
			val_c_q <= '0;
			val_p_q <= '0;
			done <= 1'b0;
			card <= '0;
			cards_left <= '0;
			refilled <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						p_q <= div_rem;
						state_q <= S_RDC;
					end
				end
				S_RDC: state_q <= S_RDP;
				S_RDP: begin
					val_c_q <= rd_data;
					state_q <= S_RDV;
				end
				S_RDV: begin
					val_p_q <= rd_data;
					state_q <= S_WRC;
				end
				S_WRC: state_q <= S_WRP;
				S_WRP: begin
					done <= 1'b1;
					card <= CARD_W'(val_p_q);
					cards_left <= LEFT_W'(c_w);
					refilled <= (c_w == '0);
					if (c_w == '0) begin
						count_q <= eff_size(deck_size_q);
						fill_q <= '0;
						state_q <= S_FILL;
					end else begin
						count_q <= c_w;
						state_q <= S_IDLE;
					end
				end
				S_FILL: begin
					fill_q <= fill_q + IDX_W'(1);
					if (fill_q == IDX_W'(MAX_CARDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_WRP))
		else $error("result word without a finished write back");
	a_left_matches: assert property (@(posedge clk) disable iff (!arst_n)
		done && !refilled |-> cards_left == LEFT_W'(count_q))
		else $error("cards left disagrees with the count");
	a_refill_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && refilled |-> busy)
		else $error("empty shoe not refilled");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not start a draw");
endmodule
